// File: hw/rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    // Field and datapath widths
    localparam int ANGLE_W   = 24;  // Q8.16 angle
    localparam int SINE_W    = 18;  // Q2.16 sine
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int RED_W     = 24;  // reduction register
    localparam int R_W       = 19;  // reduced angle, y in Q19
    localparam int Y2_W      = 38;  // y^2 in Q38
    localparam int ACC_W     = 53;  // signed Horner accumulator, Q40
    localparam int MAG_W     = 52;  // magnitude of the accumulator
    localparam int HALF_W    = 26;  // one multiplier operand chunk
    localparam int PROD_W    = 91;  // product accumulator
    localparam int COEF_W    = 50;
    localparam int MFIN_W    = 29;  // final product magnitude after shift
    localparam int PC_W      = 5;
    localparam int K_W       = 4;
    localparam int MAX_TERMS = 12;

    localparam int HORN_SHIFT = 38;
    localparam int FIN_SHIFT  = 43;

    // 2*pi in Q16, and the offset that lifts any negative angle above zero
    localparam int TWO_PI_Q16 = 411775;
    localparam int RED_OFFSET = 21 * TWO_PI_Q16;
    localparam int RED_STEPS  = 5;

    localparam int SINE_MAX = 131071;
    localparam int SINE_MIN_MAG = 131072;

    // Coefficients 8^(2k+1)/(2k+1)! in Q40, each from the one before
    localparam longint COEF_0  = longint'(1) << 43;
    localparam longint COEF_1  = (COEF_0  * 64 + 3) / 6;
    localparam longint COEF_2  = (COEF_1  * 64 + 10) / 20;
    localparam longint COEF_3  = (COEF_2  * 64 + 21) / 42;
    localparam longint COEF_4  = (COEF_3  * 64 + 36) / 72;
    localparam longint COEF_5  = (COEF_4  * 64 + 55) / 110;
    localparam longint COEF_6  = (COEF_5  * 64 + 78) / 156;
    localparam longint COEF_7  = (COEF_6  * 64 + 105) / 210;
    localparam longint COEF_8  = (COEF_7  * 64 + 136) / 272;
    localparam longint COEF_9  = (COEF_8  * 64 + 171) / 342;
    localparam longint COEF_10 = (COEF_9  * 64 + 210) / 420;
    localparam longint COEF_11 = (COEF_10 * 64 + 253) / 506;

    typedef enum logic [2:0] {
        OP_RED,
        OP_SQR,
        OP_INIT,
        OP_ABS,
        OP_MUL,
        OP_HORN,
        OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        BSEL_Y2_LO,
        BSEL_Y2_HI,
        BSEL_R
    } b_sel_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_ONE_TERM,
        COND_MORE_TERMS
    } cond_t;

    typedef struct packed {
        op_t             op;
        logic [2:0]      sh;        // reduction: subtract 2*pi << sh
        logic            a_hi;      // multiply: upper chunk of the magnitude
        b_sel_t          b_sel;     // multiply: second operand
        logic            half_fin;  // abs: preload the final rounding half
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam logic [PC_W-1:0] PC_LAST  = PC_W'(16);
    localparam logic [PC_W-1:0] PC_HORN  = PC_W'(7);
    localparam logic [PC_W-1:0] PC_FINAL = PC_W'(13);

    function automatic logic [COEF_W-1:0] coef_rom(input logic [K_W-1:0] k);
        logic [COEF_W-1:0] c;
        unique case (k)
            4'd0:    c = COEF_W'(COEF_0);
            4'd1:    c = COEF_W'(COEF_1);
            4'd2:    c = COEF_W'(COEF_2);
            4'd3:    c = COEF_W'(COEF_3);
            4'd4:    c = COEF_W'(COEF_4);
            4'd5:    c = COEF_W'(COEF_5);
            4'd6:    c = COEF_W'(COEF_6);
            4'd7:    c = COEF_W'(COEF_7);
            4'd8:    c = COEF_W'(COEF_8);
            4'd9:    c = COEF_W'(COEF_9);
            4'd10:   c = COEF_W'(COEF_10);
            4'd11:   c = COEF_W'(COEF_11);
            default: c = '0;
        endcase
        return c;
    endfunction

    // Program: reduce, square, initialise, Horner loop (abs, four partial products,
    // update), then the final abs, multiply by r and write-out.
    function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        w.op       = OP_FIN;
        w.sh       = 3'd0;
        w.a_hi     = 1'b0;
        w.b_sel    = BSEL_Y2_LO;
        w.half_fin = 1'b0;
        w.cond     = COND_NONE;
        w.target   = '0;
        unique case (pc)
            5'd0: begin w.op = OP_RED; w.sh = 3'd4; end
            5'd1: begin w.op = OP_RED; w.sh = 3'd3; end
            5'd2: begin w.op = OP_RED; w.sh = 3'd2; end
            5'd3: begin w.op = OP_RED; w.sh = 3'd1; end
            5'd4: begin w.op = OP_RED; w.sh = 3'd0; end
            5'd5: w.op = OP_SQR;
            5'd6: begin
                w.op = OP_INIT; w.cond = COND_ONE_TERM; w.target = PC_FINAL;
            end
            5'd7:  w.op = OP_ABS;
            5'd8:  begin w.op = OP_MUL; w.b_sel = BSEL_Y2_LO; end
            5'd9:  begin w.op = OP_MUL; w.b_sel = BSEL_Y2_HI; end
            5'd10: begin w.op = OP_MUL; w.a_hi = 1'b1; w.b_sel = BSEL_Y2_LO; end
            5'd11: begin w.op = OP_MUL; w.a_hi = 1'b1; w.b_sel = BSEL_Y2_HI; end
            5'd12: begin
                w.op = OP_HORN; w.cond = COND_MORE_TERMS; w.target = PC_HORN;
            end
            5'd13: begin w.op = OP_ABS; w.half_fin = 1'b1; end
            5'd14: begin w.op = OP_MUL; w.b_sel = BSEL_R; end
            5'd15: begin w.op = OP_MUL; w.a_hi = 1'b1; w.b_sel = BSEL_R; end
            5'd16: w.op = OP_FIN;
            default: w.op = OP_FIN;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sine_taylor_series.sv
`default_nettype none
// Fixed-point sine by odd Taylor series.
//
// Input channel (s_*): one signed Q8.16 angle in radians per item. The angle
// is reduced into [0, 2*pi) and its sine returned as a signed Q2.16 item on
// the result channel (m_*), saturated to the 18-bit range.
//
// A small microcode program drives the datapath: five compare-subtract steps
// reduce the angle, one step squares it on a 19x19 squarer, and each Horner
// term takes six steps (magnitude, four partial products on the one shared
// 26x19 multiplier, update). Only one item is in flight.
//
// The result sits in an output register, so a new angle is taken while the
// previous sine waits. When the receiver stalls and the next sine is ready,
// the program holds on its last step until the output register frees.
// Reset (aresetn low, synchronous) drops any item in flight and clears the
// output valid; the block keeps no state between items.
module sine_taylor_series #(
    parameter int TERMS = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sts_pkg::S_TDATA_W-1:0]  s_tdata,   // [23:0] angle
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sts_pkg::M_TDATA_W-1:0]       m_tdata    // [17:0] sine, zeros above
);

    localparam int N_TERMS = (TERMS < 1) ? 1 :
                             ((TERMS > sts_pkg::MAX_TERMS) ? sts_pkg::MAX_TERMS : TERMS);
    localparam logic [sts_pkg::K_W-1:0] K_FIRST =
        sts_pkg::K_W'((N_TERMS >= 2) ? (N_TERMS - 2) : 0);
    localparam logic [sts_pkg::K_W-1:0] K_TOP = sts_pkg::K_W'(N_TERMS - 1);
    localparam logic ONE_TERM = (N_TERMS == 1);

    localparam logic [sts_pkg::RED_W-1:0] TWO_PI = sts_pkg::RED_W'(sts_pkg::TWO_PI_Q16);

    // Control state
    logic                        busy_reg, busy_next;
    logic [sts_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic                        m_valid_reg, m_valid_next;

    // Datapath registers
    logic [sts_pkg::RED_W-1:0]   red_reg, red_next;
    logic [sts_pkg::Y2_W-1:0]    y2_reg, y2_next;
    logic [sts_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [sts_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic [sts_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [sts_pkg::K_W-1:0]     k_reg, k_next;
    logic [sts_pkg::SINE_W-1:0]  sine_reg, sine_next;

    sts_pkg::ucode_t             uc;
    logic                        accept;
    logic                        step_en;
    logic                        jump;

    logic [sts_pkg::ANGLE_W:0]   angle_lift;
    logic [sts_pkg::RED_W-1:0]   red_sub;
    logic [sts_pkg::RED_W:0]     red_diff;
    logic [sts_pkg::R_W-1:0]     r_val;
    logic [sts_pkg::HALF_W-1:0]  mul_a;
    logic [sts_pkg::R_W-1:0]     mul_b;
    logic [sts_pkg::HALF_W+sts_pkg::R_W-1:0] mul_p;
    logic [5:0]                  mul_sh;
    logic [sts_pkg::ACC_W-1:0]   acc_neg;
    logic [sts_pkg::ACC_W-1:0]   coef_ext;
    logic [sts_pkg::ACC_W-1:0]   m_horn;
    logic [sts_pkg::MFIN_W-1:0]  m_fin;

    assign uc       = sts_pkg::ucode_word(pc_reg);
    assign s_tready = aresetn & ~busy_reg;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(sts_pkg::M_TDATA_W - sts_pkg::SINE_W){1'b0}}, sine_reg};

    // Hold the last step while the previous sine still waits downstream
    assign step_en = busy_reg &
                     ~((uc.op == sts_pkg::OP_FIN) & m_valid_reg & ~m_tready);

    always_comb begin
        case (uc.cond)
            sts_pkg::COND_ONE_TERM:   jump = ONE_TERM;
            sts_pkg::COND_MORE_TERMS: jump = (k_reg != '0);
            default:                  jump = 1'b0;
        endcase
    end

    // Datapath operand and result logic
    always_comb begin
        angle_lift = {s_tdata[sts_pkg::ANGLE_W-1], s_tdata[sts_pkg::ANGLE_W-1:0]}
                     + (sts_pkg::ANGLE_W + 1)'(sts_pkg::RED_OFFSET);
        red_sub    = TWO_PI << uc.sh;
        red_diff   = {1'b0, red_reg} - {1'b0, red_sub};
        r_val      = red_reg[sts_pkg::R_W-1:0];

        mul_a = uc.a_hi ? mag_reg[sts_pkg::MAG_W-1:sts_pkg::HALF_W]
                        : mag_reg[sts_pkg::HALF_W-1:0];
        case (uc.b_sel)
            sts_pkg::BSEL_Y2_LO: mul_b = y2_reg[sts_pkg::R_W-1:0];
            sts_pkg::BSEL_Y2_HI: mul_b = y2_reg[sts_pkg::Y2_W-1:sts_pkg::R_W];
            default:             mul_b = r_val;
        endcase
        mul_p  = (sts_pkg::HALF_W + sts_pkg::R_W)'(mul_a) *
                 (sts_pkg::HALF_W + sts_pkg::R_W)'(mul_b);
        mul_sh = (uc.a_hi ? 6'(sts_pkg::HALF_W) : 6'd0) +
                 ((uc.b_sel == sts_pkg::BSEL_Y2_HI) ? 6'(sts_pkg::R_W) : 6'd0);

        acc_neg  = ~acc_reg + 1'b1;
        coef_ext = sts_pkg::ACC_W'(sts_pkg::coef_rom(k_reg));
        m_horn   = prod_reg[sts_pkg::HORN_SHIFT +: sts_pkg::ACC_W];
        m_fin    = prod_reg[sts_pkg::FIN_SHIFT +: sts_pkg::MFIN_W];
    end

    // Next-state for control and datapath
    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        red_next     = red_reg;
        y2_next      = y2_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        k_next       = k_reg;
        sine_next    = sine_reg;

        if (accept) begin
            busy_next = 1'b1;
            pc_next   = '0;
            // Lift negative angles by a multiple of 2*pi so all are positive
            red_next  = s_tdata[sts_pkg::ANGLE_W-1] ? angle_lift[sts_pkg::RED_W-1:0]
                                                    : s_tdata[sts_pkg::RED_W-1:0];
        end else if (step_en) begin
            pc_next = jump ? uc.target : sts_pkg::PC_W'(pc_reg + 1'b1);
            unique case (uc.op)
                sts_pkg::OP_RED: begin
                    if (!red_diff[sts_pkg::RED_W]) begin
                        red_next = red_diff[sts_pkg::RED_W-1:0];
                    end
                end
                sts_pkg::OP_SQR: begin
                    y2_next = sts_pkg::Y2_W'(r_val) * sts_pkg::Y2_W'(r_val);
                end
                sts_pkg::OP_INIT: begin
                    acc_next = sts_pkg::ACC_W'(sts_pkg::coef_rom(K_TOP));
                    k_next   = K_FIRST;
                end
                sts_pkg::OP_ABS: begin
                    neg_next  = acc_reg[sts_pkg::ACC_W-1];
                    mag_next  = acc_reg[sts_pkg::ACC_W-1] ? acc_neg[sts_pkg::MAG_W-1:0]
                                                          : acc_reg[sts_pkg::MAG_W-1:0];
                    // Preload the rounding half of the coming shift
                    prod_next = uc.half_fin ?
                        (sts_pkg::PROD_W'(1) << (sts_pkg::FIN_SHIFT - 1)) :
                        (sts_pkg::PROD_W'(1) << (sts_pkg::HORN_SHIFT - 1));
                end
                sts_pkg::OP_MUL: begin
                    prod_next = prod_reg + (sts_pkg::PROD_W'(mul_p) << mul_sh);
                end
                sts_pkg::OP_HORN: begin
                    // acc = coef[k] - acc*y2, with the product sign in neg_reg
                    acc_next = neg_reg ? (coef_ext + m_horn) : (coef_ext - m_horn);
                    if (k_reg != '0) begin
                        k_next = k_reg - 1'b1;
                    end
                end
                sts_pkg::OP_FIN: begin
                    if (neg_reg) begin
                        sine_next = (m_fin > sts_pkg::MFIN_W'(sts_pkg::SINE_MIN_MAG)) ?
                            sts_pkg::SINE_W'(sts_pkg::SINE_MIN_MAG) :
                            sts_pkg::SINE_W'(~m_fin + 1'b1);
                    end else begin
                        sine_next = (m_fin > sts_pkg::MFIN_W'(sts_pkg::SINE_MAX)) ?
                            sts_pkg::SINE_W'(sts_pkg::SINE_MAX) :
                            m_fin[sts_pkg::SINE_W-1:0];
                    end
                    m_valid_next = 1'b1;
                    busy_next    = 1'b0;
                    pc_next      = '0;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_reg  <= red_next;
        y2_reg   <= y2_next;
        acc_reg  <= acc_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        sine_reg <= sine_next;
    end

    // An accepted angle starts the program at its first step
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (busy_reg && pc_reg == '0))
        else $error("program did not start on accept");

    // The program counter stays inside the program
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= sts_pkg::PC_LAST))
        else $error("program counter out of range");

    // Reduction leaves the angle below 2*pi before it is squared
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && uc.op == sts_pkg::OP_SQR) |-> (red_reg < TWO_PI))
        else $error("angle not reduced below 2*pi");

    // A result appears only out of the write-out step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg && uc.op == sts_pkg::OP_FIN))
        else $error("result valid without write-out step");

    // The term index never runs past the table in use
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && uc.op == sts_pkg::OP_HORN) |-> (k_reg < K_TOP))
        else $error("term index out of range");

endmodule

`default_nettype wire
